>>> rtl/fdc_pkg.sv
// ----------------------------------------------------------------------------
// fdc_pkg
// Shared types and constants of the fan duty controller: window size,
// datapath widths, fixed-point coefficients and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package fdc_pkg;

  localparam int unsigned WINDOW = 40;

  localparam int unsigned SMP_W  = 10;
  localparam int unsigned CYC_W  = 12;
  localparam int unsigned KICK_W = 8;
  localparam int unsigned LED_W  = 3;
  localparam int unsigned SUM_W  = 16;

  localparam int unsigned POS_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned CNT_W  = $clog2(WINDOW + 1);
  localparam int unsigned PROD_W = SMP_W + CNT_W;
  localparam int unsigned N_W    = SUM_W + 6;
  localparam int unsigned D_W    = 14 + CNT_W;
  localparam int unsigned DEN_W  = D_W + 1;
  localparam int unsigned NUM_W  = CYC_W + N_W + 1;

  localparam int unsigned OFFSET_K = 3069;
  localparam int unsigned SCALE_K  = 10230;

  localparam logic [SMP_W-1:0] KNOB_TOP  = SMP_W'(1023);
  localparam logic [SMP_W-1:0] KNOB_HIGH = SMP_W'(682);
  localparam logic [SMP_W-1:0] KNOB_MID  = SMP_W'(341);

  localparam logic [LED_W-1:0] LED_NONE  = 3'd0;
  localparam logic [LED_W-1:0] LED_ONE   = 3'd1;
  localparam logic [LED_W-1:0] LED_TWO   = 3'd3;
  localparam logic [LED_W-1:0] LED_THREE = 3'd7;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 12;
  localparam logic [CFG_IDX_W-1:0] CFG_CYCLE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_ON = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KICK   = 2'd2;

  localparam logic [CYC_W-1:0]  CYCLE_RST  = 12'd2000;
  localparam logic [CYC_W-1:0]  MIN_ON_RST = 12'd200;
  localparam logic [KICK_W-1:0] KICK_RST   = 8'd20;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM,
    ST_PROD,
    ST_NUMR,
    ST_MULT,
    ST_START,
    ST_DIV,
    ST_CLAMP,
    ST_FINISH
  } fdc_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

`default_nettype wire

>>> rtl/fan_duty_controller_top.sv
// ----------------------------------------------------------------------------
// fan_duty_controller_top
// Moving-average proportional fan duty control with kick start and knob bar.
//
//   channel  direction  handshake                  payload
//   in       sink       in_valid_i / in_stall_o    temp_sample_i, knob_sample_i
//   out      source     out_valid_o / out_stall_i  on_length_o, full_power_o,
//                                                  level_leds_o
//   cfg      sink       cfg_we_i                   cfg_index_i, cfg_data_i
//
// Each word passes ST_SUM, ST_PROD, ST_NUMR, ST_MULT and ST_START, the serial
// divider (35 quotient bits, one per cycle), then ST_CLAMP and ST_FINISH.
// in_stall_o is high from accept until the result is loaded into the output
// register; a word may be accepted while that result waits on out_stall_i.
// Reset clears the window count, sum, kick state and restores the registers.
// ----------------------------------------------------------------------------
`default_nettype none

module fan_duty_controller_top
  import fdc_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [SMP_W-1:0]     temp_sample_i,
  input  wire logic [SMP_W-1:0]     knob_sample_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic      [CYC_W-1:0]     on_length_o,
  output logic                      full_power_o,
  output logic      [LED_W-1:0]     level_leds_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i
);

  fdc_state_e state_q, state_d;

  logic [CYC_W-1:0]  cycle_q;
  logic [CYC_W-1:0]  min_on_q;
  logic [KICK_W-1:0] kick_len_q;

  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic              full_q, full_d;
  logic [CYC_W-1:0]  last_on_q, last_on_d;
  logic [KICK_W-1:0] kick_q, kick_d;

  logic [SMP_W-1:0]  temp_q;
  logic [SMP_W-1:0]  knob_q;
  logic [LED_W-1:0]  level_q;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [PROD_W-1:0] prod_q;
  logic [N_W-1:0]    n_q;
  logic [D_W-1:0]    d_q;
  logic [NUM_W-1:0]  dividend_q;
  logic              npos_q;
  logic [CYC_W-1:0]  on_q;

  logic              out_valid_q;
  logic [CYC_W-1:0]  out_on_q;
  logic              out_fp_q;
  logic [LED_W-1:0]  out_level_q;

  logic              accept;
  logic              load_out;
  logic              div_start;
  div_status_t       div_status;
  logic [NUM_W-1:0]  quot;
  logic [SMP_W-1:0]  ring_rdata;
  logic              ring_we;
  logic [LED_W-1:0]  level_d;
  logic [N_W-1:0]    n_d;
  logic              npos_d;
  logic [CYC_W-1:0]  on_d;
  logic              fp_d;
  logic [CNT_W:0]    pos_inc;
  logic [KICK_W-1:0] kick_arm;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign ring_we    = (state_q == ST_SUM);

  fdc_ram #(
    .WIDTH (SMP_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (pos_q),
    .wdata_i (temp_q),
    .re_i    (accept),
    .raddr_i (pos_q),
    .rdata_o (ring_rdata)
  );

  fdc_divider u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .num_i    (dividend_q),
    .den_i    ({d_q, 1'b0}),
    .status_o (div_status),
    .quot_o   (quot)
  );

  always_comb begin
    if (knob_sample_i == KNOB_TOP) begin
      level_d = LED_NONE;
    end else if (knob_sample_i >= KNOB_HIGH) begin
      level_d = LED_ONE;
    end else if (knob_sample_i >= KNOB_MID) begin
      level_d = LED_TWO;
    end else begin
      level_d = LED_THREE;
    end
  end

  always_comb begin
    pos_inc = (CNT_W + 1)'(pos_q) + 1'b1;
    if (pos_inc >= (CNT_W + 1)'(WINDOW)) begin
      pos_d  = '0;
      full_d = 1'b1;
    end else begin
      pos_d  = pos_inc[POS_W-1:0];
      full_d = full_q;
    end
    count_d = full_d ? CNT_W'(WINDOW) : CNT_W'(pos_d);
    sum_d   = sum_q - (full_q ? SUM_W'(ring_rdata) : '0) + SUM_W'(temp_q);
  end

  always_comb begin
    n_d = (N_W'(sum_q) << 4) + (N_W'(sum_q) << 2)
        - (N_W'(prod_q) << 3) - (N_W'(prod_q) << 1)
        - N_W'(OFFSET_K) * N_W'(count_q);
    npos_d = !n_d[N_W-1] && (n_d != '0);
  end

  always_comb begin
    if (!npos_q) begin
      on_d = '0;
    end else if ((quot != '0) && (quot < NUM_W'(min_on_q))) begin
      on_d = '0;
    end else if (quot > NUM_W'(cycle_q)) begin
      on_d = cycle_q;
    end else begin
      on_d = quot[CYC_W-1:0];
    end
  end

  always_comb begin
    kick_arm = ((last_on_q == '0) && (on_q >= min_on_q)) ? kick_len_q : kick_q;
    fp_d     = (kick_arm != '0);
    kick_d   = fp_d ? kick_arm - 1'b1 : kick_arm;
    last_on_d = on_q;
  end

  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    load_out  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_SUM;
      end
      ST_SUM:   state_d = ST_PROD;
      ST_PROD:  state_d = ST_NUMR;
      ST_NUMR:  state_d = ST_MULT;
      ST_MULT:  state_d = ST_START;
      ST_START: begin
        div_start = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (div_status.done) state_d = ST_CLAMP;
      end
      ST_CLAMP: state_d = ST_FINISH;
      ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cycle_q     <= CYCLE_RST;
      min_on_q    <= MIN_ON_RST;
      kick_len_q  <= KICK_RST;
      sum_q       <= '0;
      pos_q       <= '0;
      full_q      <= 1'b0;
      last_on_q   <= '0;
      kick_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_CYCLE:  cycle_q    <= cfg_data_i;
          CFG_MIN_ON: min_on_q   <= cfg_data_i;
          CFG_KICK:   kick_len_q <= cfg_data_i[KICK_W-1:0];
          default: ;
        endcase
      end
      if (state_q == ST_SUM) begin
        sum_q  <= sum_d;
        pos_q  <= pos_d;
        full_q <= full_d;
      end
      if (load_out) begin
        last_on_q   <= last_on_d;
        kick_q      <= kick_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      temp_q  <= temp_sample_i;
      knob_q  <= knob_sample_i;
      level_q <= level_d;
    end
    if (state_q == ST_SUM) begin
      count_q <= count_d;
    end
    if (state_q == ST_PROD) begin
      prod_q <= PROD_W'(knob_q) * PROD_W'(count_q);
    end
    if (state_q == ST_NUMR) begin
      n_q    <= n_d;
      npos_q <= npos_d;
      d_q    <= D_W'(D_W'(SCALE_K) * D_W'(count_q));
    end
    if (state_q == ST_MULT) begin
      dividend_q <= npos_q
                  ? NUM_W'({cycle_q, 1'b0}) * NUM_W'(n_q[N_W-2:0]) + NUM_W'(d_q)
                  : '0;
    end
    if (state_q == ST_CLAMP) begin
      on_q <= on_d;
    end
    if (load_out) begin
      out_on_q    <= on_q;
      out_fp_q    <= fp_d;
      out_level_q <= level_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign on_length_o  = out_on_q;
  assign full_power_o = out_fp_q;
  assign level_leds_o = out_level_q;

endmodule

`default_nettype wire

>>> rtl/fdc_ram.sv
// ----------------------------------------------------------------------------
// fdc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fdc_ram #(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned DEPTH = 40
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                         wdata_i,
  input  wire logic                                     re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/fdc_divider.sv
// ----------------------------------------------------------------------------
// fdc_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fdc_divider
  import fdc_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output div_status_t           status_o,
  output logic      [NUM_W-1:0] quot_o
);

  localparam int unsigned STEP_W = $clog2(NUM_W);

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] step_q;
  logic [NUM_W-1:0]  quo_q;
  logic [DEN_W-1:0]  rem_q;
  logic [DEN_W-1:0]  rem_d;
  logic [DEN_W-1:0]  den_q;
  logic [DEN_W:0]    rem_sh;
  logic              qbit;

  always_comb begin
    rem_sh = {rem_q, quo_q[NUM_W-1]};
    if (rem_sh >= {1'b0, den_q}) begin
      qbit  = 1'b1;
      rem_d = DEN_W'(rem_sh - {1'b0, den_q});
    end else begin
      qbit  = 1'b0;
      rem_d = rem_sh[DEN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        step_q <= STEP_W'(NUM_W - 1);
      end else if (busy_q) begin
        step_q <= step_q - 1'b1;
        if (step_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[NUM_W-2:0], qbit};
      rem_q <= rem_d;
    end
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quot_o        = quo_q;

endmodule

`default_nettype wire

>>> dv/fan_duty_controller_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fan_duty_controller_top_tb
// Self-checking bench for the fan duty controller. A short directed table
// (reset state, knob thresholds, field extremes, kick start) is followed by
// phases of random temperature/knob words under several register settings.
// Each accepted word is run through an in-bench duty predictor and every
// result word is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------

module fan_duty_controller_top_tb;
  import fdc_pkg::*;

  localparam int HALF_PERIOD = 4;
  localparam int RESET_CYCLES = 10;
  localparam int IDLE_PCT = 21;
  localparam int HOLD_CYCLES = 600;
  localparam int SETTLE_CYCLES = 60;
  localparam int QUIET_LIMIT = 4000;
  localparam int NUM_PHASES = 8;
  localparam int PHASE_WORDS = 190;
  localparam int CALM_PHASE = 0;
  localparam int HOLD_PHASE = 2;
  localparam int SPARE_PHASE = 3;
  localparam int PAUSE_PHASE = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic [CYC_W-1:0] on_length;
    logic             full_power;
    logic [LED_W-1:0] level_leds;
  } duty_word_t;

  typedef struct packed {
    logic [SMP_W-1:0] temp;
    logic [SMP_W-1:0] knob;
    logic             typed;
    duty_word_t       want;
  } stim_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [SMP_W-1:0]     temp_sample_i;
  logic [SMP_W-1:0]     knob_sample_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [CYC_W-1:0]     on_length_o;
  logic                 full_power_o;
  logic [LED_W-1:0]     level_leds_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]     cfg_data_i;

  fan_duty_controller_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .temp_sample_i (temp_sample_i),
    .knob_sample_i (knob_sample_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .on_length_o   (on_length_o),
    .full_power_o  (full_power_o),
    .level_leds_o  (level_leds_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // predictor state and register copy
  logic [SMP_W-1:0]  win_ring [WINDOW];
  logic [SUM_W-1:0]  win_sum;
  int                win_pos;
  bit                win_full;
  logic [CYC_W-1:0]  prev_on;
  logic [KICK_W-1:0] kick_left;
  logic [CYC_W-1:0]  reg_cycle;
  logic [CYC_W-1:0]  reg_min_on;
  logic [KICK_W-1:0] reg_kick;

  duty_word_t duty_q[$];
  stim_row_t  dir_rows[$];
  bit         cur_typed;
  duty_word_t cur_want;
  bit         calm;
  bit         hold_req;
  int         err_cnt;

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    temp_sample_i = '0;
    knob_sample_i = '0;
    out_stall_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    cur_typed = 1'b0;
    cur_want = '0;
    calm = 1'b0;
    hold_req = 1'b0;
    err_cnt = 0;
    win_sum = '0;
    win_pos = 0;
    win_full = 1'b0;
    prev_on = '0;
    kick_left = '0;
    reg_cycle = CYCLE_RST;
    reg_min_on = MIN_ON_RST;
    reg_kick = KICK_RST;
  end

  always #(HALF_PERIOD) clk_i = ~clk_i;

  task automatic predict_duty(input logic [SMP_W-1:0] t, input logic [SMP_W-1:0] k,
                              output duty_word_t w);
    longint cnt;
    longint num;
    longint den;
    longint duty;
    if (win_full) win_sum = win_sum - win_ring[win_pos];
    win_ring[win_pos] = t;
    win_sum = win_sum + t;
    win_pos++;
    if (win_pos >= WINDOW) begin
      win_pos = 0;
      win_full = 1'b1;
    end
    cnt = win_full ? longint'(WINDOW) : longint'(win_pos);
    num = 20 * longint'(win_sum) - 10 * longint'(k) * cnt - longint'(OFFSET_K) * cnt;
    if (num <= 0) begin
      duty = 0;
    end else begin
      den = longint'(SCALE_K) * cnt;
      duty = (2 * longint'(reg_cycle) * num + den) / (2 * den);
    end
    if (duty > 0 && duty < longint'(reg_min_on)) duty = 0;
    else if (duty > longint'(reg_cycle)) duty = longint'(reg_cycle);
    if (prev_on == '0 && duty >= longint'(reg_min_on)) kick_left = reg_kick;
    prev_on = duty[CYC_W-1:0];
    w.full_power = (kick_left != '0);
    if (kick_left != '0) kick_left = kick_left - 1'b1;
    w.on_length = duty[CYC_W-1:0];
    if (k == KNOB_TOP) w.level_leds = LED_NONE;
    else if (k >= KNOB_HIGH) w.level_leds = LED_ONE;
    else if (k >= KNOB_MID) w.level_leds = LED_TWO;
    else w.level_leds = LED_THREE;
  endtask

  always @(posedge clk_i) begin : word_in
    duty_word_t w;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      predict_duty(temp_sample_i, knob_sample_i, w);
      if (cur_typed) w = cur_want;
      duty_q.push_back(w);
    end
  end

  always @(posedge clk_i) begin : word_out
    duty_word_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (duty_q.size() == 0) begin
        $display("%0t unexpected word: on_length %0d full_power %0d level_leds %0d",
                 $time, on_length_o, full_power_o, level_leds_o);
        err_cnt++;
      end else begin
        w = duty_q.pop_front();
        if (on_length_o !== w.on_length) begin
          $display("%0t on_length expected %0d actual %0d", $time, w.on_length, on_length_o);
          err_cnt++;
        end
        if (full_power_o !== w.full_power) begin
          $display("%0t full_power expected %0d actual %0d", $time, w.full_power,
                   full_power_o);
          err_cnt++;
        end
        if (level_leds_o !== w.level_leds) begin
          $display("%0t level_leds expected %0d actual %0d", $time, w.level_leds,
                   level_leds_o);
          err_cnt++;
        end
      end
    end
  end

  initial begin : receiver
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else begin
        out_stall_i <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic add_row(input int t, input int k, input bit typed, input int on_len,
                         input bit fp, input logic [LED_W-1:0] leds);
    stim_row_t r;
    r.temp = SMP_W'(t);
    r.knob = SMP_W'(k);
    r.typed = typed;
    r.want.on_length = CYC_W'(on_len);
    r.want.full_power = fp;
    r.want.level_leds = leds;
    dir_rows.push_back(r);
  endtask

  task automatic send_word(input logic [SMP_W-1:0] t, input logic [SMP_W-1:0] k,
                           input bit typed, input duty_word_t want);
    bit took;
    took = 1'b0;
    @(negedge clk_i);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    cur_typed = typed;
    cur_want = want;
    in_valid_i <= 1'b1;
    temp_sample_i <= t;
    knob_sample_i <= k;
    while (!took) begin
      @(posedge clk_i);
      took = !in_stall_o;
    end
  endtask

  task automatic drain_words();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (duty_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_CYCLE:  reg_cycle = val;
      CFG_MIN_ON: reg_min_on = val;
      CFG_KICK:   reg_kick = val[KICK_W-1:0];
      default: ;
    endcase
  endtask

  function automatic int clamp_smp(input int v);
    if (v < 0) return 0;
    if (v > 1023) return 1023;
    return v;
  endfunction

  initial begin : stimulus
    int c;
    int m;
    int kk;
    int lvl;
    int offs;
    logic [SMP_W-1:0] t;
    logic [SMP_W-1:0] k;
    stim_row_t r;

    // reset state, extremes and kick start against reset registers
    add_row(0, 1023, 1'b1, 0, 1'b0, LED_NONE);
    add_row(1023, 0, 1'b1, 1400, 1'b1, LED_THREE);
    add_row(1023, 1023, 1'b1, 0, 1'b1, LED_NONE);
    add_row(1023, 682, 1'b0, 0, 1'b0, LED_NONE);
    add_row(1023, 681, 1'b0, 0, 1'b0, LED_NONE);
    add_row(900, 341, 1'b0, 0, 1'b0, LED_NONE);
    add_row(900, 340, 1'b0, 0, 1'b0, LED_NONE);
    add_row(1023, 1022, 1'b0, 0, 1'b0, LED_NONE);
    add_row(682, 0, 1'b0, 0, 1'b0, LED_NONE);
    add_row(341, 1, 1'b0, 0, 1'b0, LED_NONE);
    add_row(0, 0, 1'b0, 0, 1'b0, LED_NONE);
    add_row(0, 0, 1'b0, 0, 1'b0, LED_NONE);
    add_row(0, 0, 1'b0, 0, 1'b0, LED_NONE);
    add_row(0, 0, 1'b0, 0, 1'b0, LED_NONE);
    add_row(1, 2, 1'b0, 0, 1'b0, LED_NONE);
    add_row(1023, 0, 1'b0, 0, 1'b0, LED_NONE);
    add_row(1023, 0, 1'b0, 0, 1'b0, LED_NONE);
    add_row(1023, 0, 1'b0, 0, 1'b0, LED_NONE);
    add_row(512, 512, 1'b0, 0, 1'b0, LED_NONE);
    add_row(170, 853, 1'b0, 0, 1'b0, LED_NONE);
    add_row(853, 170, 1'b0, 0, 1'b0, LED_NONE);
    add_row(1022, 1, 1'b0, 0, 1'b0, LED_NONE);
    add_row(1023, 0, 1'b0, 0, 1'b0, LED_NONE);

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      send_word(r.temp, r.knob, r.typed, r.want);
    end

    lvl = 512;
    offs = 400;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_words();
      repeat (SETTLE_CYCLES) @(posedge clk_i);
      case (ph)
        0: begin c = 4095; m = 0; kk = 255; end
        1: begin c = 0; m = 4095; kk = 0; end
        2: begin c = 1; m = 0; kk = 1; end
        3: begin c = 4095; m = 4095; kk = 255; end
        5: begin c = 2000; m = 200; kk = 20; end
        7: begin c = 300; m = 150; kk = 3; end
        default: begin
          c = $urandom_range(1, 4095);
          m = $urandom_range(0, c);
          kk = $urandom_range(0, 255);
        end
      endcase
      write_reg(CFG_CYCLE, CFG_W'(c));
      write_reg(CFG_MIN_ON, CFG_W'(m));
      write_reg(CFG_KICK, {4'($urandom), 8'(kk)});
      if (ph == SPARE_PHASE) write_reg(CFG_SPARE, CFG_W'($urandom));
      @(negedge clk_i);
      cfg_we_i <= 1'b0;
      calm = (ph == CALM_PHASE);

      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (ph == HOLD_PHASE && n == 20) hold_req = 1'b1;
        if (ph == PAUSE_PHASE && n == PHASE_WORDS / 2) drain_words();
        if ($urandom_range(0, 99) < 15) begin
          t = SMP_W'($urandom);
          k = SMP_W'($urandom);
        end else begin
          if ($urandom_range(0, 99) < 2) begin
            lvl = $urandom_range(0, 1023);
            offs = $urandom_range(0, 1200) - 200;
          end
          lvl = clamp_smp(lvl + int'($urandom_range(0, 32)) - 16);
          offs = offs + int'($urandom_range(0, 48)) - 24;
          if (offs < -200) offs = -200;
          if (offs > 1200) offs = 1200;
          // steer the knob so the demand sweeps through zero and full scale
          t = SMP_W'(clamp_smp(lvl + int'($urandom_range(0, 16)) - 8));
          k = SMP_W'(clamp_smp(2 * lvl - 307 - offs));
        end
        send_word(t, k, 1'b0, '0);
      end
    end
    calm = 1'b0;

    drain_words();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/fdc_pkg.sv
rtl/fdc_ram.sv
rtl/fdc_divider.sv
rtl/fan_duty_controller_top.sv
dv/fan_duty_controller_top_tb.sv
